FILE: design/xsfb_pkg.sv
// ----------------------------------------------------------------------------
// xsfb_pkg
// Shared types and constants for the XOR sprite framebuffer.
// ----------------------------------------------------------------------------
package xsfb_pkg;

    localparam int SPRITE_BITS   = 8;
    localparam int COORD_BITS    = 8;
    localparam int INDEX_BITS    = 4;
    localparam int ROW_SUM_BITS  = COORD_BITS + 1;
    localparam int S_TDATA_BITS  = 32;
    localparam int M_TDATA_BITS  = 8;

    typedef enum logic {
        OP_DRAW  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    // Input beat payload as carried by s_tdata, highest field first.
    typedef struct packed {
        logic [3:0]             pad;
        logic [SPRITE_BITS-1:0] sprite_bits;
        logic [INDEX_BITS-1:0]  row_index;
        logic [COORD_BITS-1:0]  origin_y;
        logic [COORD_BITS-1:0]  origin_x;
    } draw_beat_t;

endpackage

FILE: design/xsfb_ram.sv
// ----------------------------------------------------------------------------
// xsfb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xsfb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/xor_sprite_framebuffer.sv
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer
// Pipeline: an accepted input beat passes the RAM read stage, then the
// result register. Throughput: one beat per cycle unless m_tready stalls;
// each draw is one read-modify-write of a single screen row (RAM read at
// accept, XOR and write-back when stage 1 advances to the result register).
// Reset: synchronous, active low; screen reads as blank right after reset
// (per-row valid bits), collision flag cleared, no clearing pass.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // origin_x [7:0], origin_y [15:8], row_index [19:16], sprite_bits [27:20]
    input  logic [xsfb_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  logic                              s_tlast,   // last_row
    input  logic                              s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // collision [0]
    output logic [xsfb_pkg::M_TDATA_BITS-1:0] m_tdata,
    output logic                              m_tlast    // sprite_done
);

    import xsfb_pkg::*;

    localparam int AW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int CW = $clog2(SCREEN_WIDTH);

    draw_beat_t                  s_beat;
    logic                        accept;
    logic                        advance;
    logic [ROW_SUM_BITS-1:0]     in_row;
    logic [AW-1:0]               rd_addr;

    // stage 1: accepted beat, RAM read in flight
    logic                        s1_valid_reg;
    op_t                         s1_op_reg;
    logic [COORD_BITS-1:0]       s1_x_reg;
    logic [ROW_SUM_BITS-1:0]     s1_row_reg;
    logic [SPRITE_BITS-1:0]      s1_bits_reg;
    logic                        s1_last_reg;

    logic [SCREEN_HEIGHT-1:0]    row_valid_reg;
    logic                        accum_reg;
    logic                        accum_next;

    // bypass for a write that landed on the same edge as this beat's read
    logic                        fwd_hit_reg;
    logic [AW-1:0]               fwd_addr_reg;
    logic [SCREEN_WIDTH-1:0]     fwd_data_reg;

    logic [SCREEN_WIDTH-1:0]     ram_rdata;
    logic [SCREEN_WIDTH-1:0]     old_row;
    logic [SCREEN_WIDTH-1:0]     mask;
    logic [AW-1:0]               s1_addr;
    logic                        in_range;
    logic                        wr_en;
    logic [SCREEN_WIDTH-1:0]     wr_data;
    logic                        hit;
    logic                        collision_out;

    logic                        m_valid_reg;
    logic                        collision_reg;
    logic                        done_reg;

    assign s_beat   = draw_beat_t'(s_tdata);
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign in_row   = ROW_SUM_BITS'(s_beat.origin_y) + ROW_SUM_BITS'(s_beat.row_index);
    assign rd_addr  = in_row[AW-1:0];

    assign s1_addr  = s1_row_reg[AW-1:0];
    assign in_range = s1_row_reg < ROW_SUM_BITS'(SCREEN_HEIGHT);

    always_comb begin
        logic [ROW_SUM_BITS-1:0] col;
        mask = '0;
        for (int i = 0; i < SPRITE_BITS; i++) begin
            col = ROW_SUM_BITS'(s1_x_reg) + ROW_SUM_BITS'(i);
            if (s1_bits_reg[SPRITE_BITS-1-i] && (col < ROW_SUM_BITS'(SCREEN_WIDTH))) begin
                mask[col[CW-1:0]] = 1'b1;
            end
        end
    end

    always_comb begin
        if (fwd_hit_reg && (fwd_addr_reg == s1_addr)) begin
            old_row = fwd_data_reg;
        end else if (row_valid_reg[s1_addr]) begin
            old_row = ram_rdata;
        end else begin
            old_row = '0;
        end
    end

    assign wr_en   = advance && s1_valid_reg && (s1_op_reg == OP_DRAW) && in_range;
    assign wr_data = old_row ^ mask;
    assign hit     = in_range && ((old_row & mask) != '0);

    always_comb begin
        if (s1_op_reg == OP_CLEAR) begin
            collision_out = 1'b0;
            accum_next    = 1'b0;
        end else begin
            collision_out = accum_reg || hit;
            accum_next    = s1_last_reg ? 1'b0 : collision_out;
        end
    end

    xsfb_ram #(
        .WIDTH (SCREEN_WIDTH),
        .DEPTH (SCREEN_HEIGHT)
    ) u_screen (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            accum_reg     <= 1'b0;
            row_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (advance && s1_valid_reg) begin
                accum_reg <= accum_next;
                if (s1_op_reg == OP_CLEAR) begin
                    row_valid_reg <= '0;
                end else if (in_range) begin
                    row_valid_reg[s1_addr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg   <= op_t'(s_tuser);
            s1_x_reg    <= s_beat.origin_x;
            s1_row_reg  <= in_row;
            s1_bits_reg <= s_beat.sprite_bits;
            s1_last_reg <= s_tlast;
        end
        if (wr_en) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= wr_data;
        end
        if (advance && s1_valid_reg) begin
            collision_reg <= collision_out;
            done_reg      <= (s1_op_reg == OP_CLEAR) || s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS-1){1'b0}}, collision_reg};
    assign m_tlast  = done_reg;

endmodule
